/* rtl/core/lse_pkg.sv */
`default_nettype none
package lse_pkg;

    localparam int DEPTH          = 1024;
    localparam int AW             = $clog2(DEPTH);
    localparam int CW             = AW + 1;
    localparam int VW             = 32;
    localparam int LIMIT_W        = 20;
    localparam int TERM_FRAC_BITS = 24;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd524288;
    localparam logic [31:0]        LN2_Q32     = 32'd2977044472;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_EXP  = 2'd1;
    localparam logic [1:0] ERR_ZERO = 2'd2;
    localparam logic [1:0] ERR_LEN  = 2'd3;

    typedef enum logic [18:0] {
        S_IDLE   = 19'b000_0000_0000_0000_0001,
        S_RD     = 19'b000_0000_0000_0000_0010,
        S_DIF    = 19'b000_0000_0000_0000_0100,
        S_KRED   = 19'b000_0000_0000_0000_1000,
        S_EMUL   = 19'b000_0000_0000_0001_0000,
        S_EDIV   = 19'b000_0000_0000_0010_0000,
        S_EDW    = 19'b000_0000_0000_0100_0000,
        S_SHIFT  = 19'b000_0000_0000_1000_0000,
        S_NEXT   = 19'b000_0000_0001_0000_0000,
        S_LOGCHK = 19'b000_0000_0010_0000_0000,
        S_NORM   = 19'b000_0000_0100_0000_0000,
        S_ZDW    = 19'b000_0000_1000_0000_0000,
        S_Z2MUL  = 19'b000_0001_0000_0000_0000,
        S_Z2     = 19'b000_0010_0000_0000_0000,
        S_LDIV   = 19'b000_0100_0000_0000_0000,
        S_LDW    = 19'b000_1000_0000_0000_0000,
        S_LMUL   = 19'b001_0000_0000_0000_0000,
        S_LNX    = 19'b010_0000_0000_0000_0000,
        S_FIN    = 19'b100_0000_0000_0000_0000
    } t_state;

endpackage
`default_nettype wire

/* rtl/core/log_sum_exp_reduce.sv */
// loading: elements are stored while idle; the final element starts the reduction
// reduction: an element below the exp floor adds a zero term, else range reduction and
// 13 taylor steps (multiply, reciprocal multiply, correct) on one shared 32x32 multiplier
// log step: includes a 64-step divide; no new element is taken meanwhile
// reset: synchronous, active low; clears the vector state and sets the limit to 8.0
`default_nettype none
module log_sum_exp_reduce (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire signed [lse_pkg::VW-1:0]        i_value,
    input  wire signed [lse_pkg::VW-1:0]        i_given_max,
    input  wire                                 i_use_given_max,
    input  wire                                 i_last,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic signed [lse_pkg::VW-1:0]       o_log_sum,
    output logic [1:0]                          o_error_code,
    input  wire                                 i_cfg_wr_en,
    input  wire [lse_pkg::LIMIT_W-1:0]          i_cfg_wr_data
);
    import lse_pkg::*;

    localparam logic signed [49:0] L50 = $signed({18'b0, LN2_Q32});
    localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;

    t_state r_state, n_state;
    logic [LIMIT_W-1:0] r_limit, n_limit;
    logic signed [VW-1:0] r_top, n_top;
    logic [CW-1:0] r_count, n_count;
    logic r_given, n_given, r_ovf, n_ovf;
    logic [AW-1:0] r_idx, n_idx;
    logic [VW-1:0] r_rdata;
    logic signed [49:0] r_rem, n_rem;
    logic signed [7:0] r_k, n_k;
    logic [31:0] r_t, n_t;
    logic [33:0] r_e, n_e;
    logic [3:0] r_n, n_n;
    logic [63:0] r_term, n_term;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_a, n_a;
    logic [5:0] r_p, n_p;
    logic [31:0] r_z, n_z, r_z2, n_z2, r_zp, n_zp;
    logic [3:0] r_j, n_j;
    logic [36:0] r_lacc, n_lacc;
    logic [1:0] r_err, n_err;
    logic [63:0] r_prod, n_prod;
    logic [63:0] r_dq, n_dq;
    logic [34:0] r_drem, n_drem;
    logic [33:0] r_dv, n_dv;
    logic [6:0] r_dcnt, n_dcnt;
    logic r_out_valid, n_out_valid;
    logic signed [VW-1:0] r_log_sum, n_log_sum;
    logic [1:0] r_err_out, n_err_out;

    logic [VW-1:0] mem [DEPTH];

    logic in_acc, first, room, cur_given;
    logic signed [VW-1:0] cur_top;
    logic signed [32:0] d;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic div_start;
    logic [63:0] div_dividend;
    logic [33:0] div_divisor;
    logic [6:0] div_bits;
    logic [34:0] rem_sh;
    logic rem_ge;
    logic [31:0] fix_x, fix_q0, fix_q, fix_qn, fix_rem;
    logic [4:0] fix_n;
    logic signed [7:0] sft, nsh;
    logic [63:0] ext_e, term_val;
    logic [64:0] sum65;
    logic signed [7:0] pd;
    logic signed [40:0] pm;
    logic signed [47:0] ln_v, ln_r, qv, total;

    // floor(2^32 / n) for n up to 15 and odd n up to 31, all ones for n = 1, zero otherwise
    function automatic logic [31:0] recip(input logic [4:0] dv);
        case (dv)
            5'd1:    recip = 32'hFFFF_FFFF;
            5'd2:    recip = 32'(Q32_ONE / 33'd2);
            5'd3:    recip = 32'(Q32_ONE / 33'd3);
            5'd4:    recip = 32'(Q32_ONE / 33'd4);
            5'd5:    recip = 32'(Q32_ONE / 33'd5);
            5'd6:    recip = 32'(Q32_ONE / 33'd6);
            5'd7:    recip = 32'(Q32_ONE / 33'd7);
            5'd8:    recip = 32'(Q32_ONE / 33'd8);
            5'd9:    recip = 32'(Q32_ONE / 33'd9);
            5'd10:   recip = 32'(Q32_ONE / 33'd10);
            5'd11:   recip = 32'(Q32_ONE / 33'd11);
            5'd12:   recip = 32'(Q32_ONE / 33'd12);
            5'd13:   recip = 32'(Q32_ONE / 33'd13);
            5'd14:   recip = 32'(Q32_ONE / 33'd14);
            5'd15:   recip = 32'(Q32_ONE / 33'd15);
            5'd17:   recip = 32'(Q32_ONE / 33'd17);
            5'd19:   recip = 32'(Q32_ONE / 33'd19);
            5'd21:   recip = 32'(Q32_ONE / 33'd21);
            5'd23:   recip = 32'(Q32_ONE / 33'd23);
            5'd25:   recip = 32'(Q32_ONE / 33'd25);
            5'd27:   recip = 32'(Q32_ONE / 33'd27);
            5'd29:   recip = 32'(Q32_ONE / 33'd29);
            5'd31:   recip = 32'(Q32_ONE / 33'd31);
            default: recip = '0;
        endcase
    endfunction

    assign in_acc    = i_in_valid && (r_state == S_IDLE);
    assign first     = (r_count == '0) && !r_ovf;
    assign room      = r_count < CW'(DEPTH);
    assign cur_given = first ? i_use_given_max : r_given;
    assign cur_top   = first ? (i_use_given_max ? i_given_max : i_value) : r_top;
    assign d         = $signed({r_rdata[31], r_rdata}) - $signed({r_top[31], r_top});
    assign mul_p     = mul_a * mul_b;
    assign rem_sh    = {r_drem[33:0], r_dq[63]};
    assign rem_ge    = rem_sh >= {1'b0, r_dv};
    assign sum65     = {1'b0, r_acc} + {1'b0, r_term};

    // reciprocal quotient is low by at most one
    assign fix_q0  = r_prod[63:32];
    assign fix_x   = (r_state == S_LDW) ? r_zp : r_t;
    assign fix_n   = (r_state == S_LDW) ? {r_j, 1'b1} : {1'b0, r_n};
    assign fix_qn  = fix_q0 * {27'b0, fix_n};
    assign fix_rem = fix_x - fix_qn;
    assign fix_q   = fix_q0 + {31'b0, (fix_rem >= {27'b0, fix_n})};

    // term scaling by 2^(k + frac - 32)
    assign sft   = r_k + 8'(TERM_FRAC_BITS) - 8'sd32;
    assign nsh   = -sft;
    assign ext_e = {30'b0, r_e};
    always_comb begin
        if (!sft[7]) begin
            term_val = ext_e << sft[3:0];
        end else if (nsh >= 8'sd40) begin
            term_val = '0;
        end else begin
            term_val = (ext_e + (64'd1 << (nsh[5:0] - 6'd1))) >> nsh[5:0];
        end
    end

    // final q16.16 result
    assign pd    = $signed({2'b0, r_p}) - 8'(TERM_FRAC_BITS);
    assign pm    = pd * $signed({1'b0, LN2_Q32});
    assign ln_v  = {{7{pm[40]}}, pm} + $signed({10'b0, r_lacc, 1'b0});
    assign ln_r  = ln_v + 48'sd32768;
    assign qv    = ln_r >>> 16;
    assign total = {{16{r_top[31]}}, r_top} + qv;

    always_comb begin
        n_state = r_state;     n_limit = r_limit;   n_top = r_top;
        n_count = r_count;     n_given = r_given;   n_ovf = r_ovf;
        n_idx = r_idx;         n_rem = r_rem;       n_k = r_k;
        n_t = r_t;             n_e = r_e;           n_n = r_n;
        n_term = r_term;       n_acc = r_acc;       n_a = r_a;
        n_p = r_p;             n_z = r_z;           n_z2 = r_z2;
        n_zp = r_zp;           n_j = r_j;           n_lacc = r_lacc;
        n_err = r_err;         n_prod = r_prod;     n_dq = r_dq;
        n_drem = r_drem;       n_dv = r_dv;         n_dcnt = r_dcnt;
        n_out_valid = r_out_valid;
        n_log_sum = r_log_sum; n_err_out = r_err_out;
        mul_a = r_zp;
        mul_b = r_z2;
        div_start = 1'b0;
        div_dividend = '0;
        div_divisor = '0;
        div_bits = '0;

        if (i_cfg_wr_en) begin
            n_limit = i_cfg_wr_data;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_given = cur_given;
                    n_top = cur_top;
                    if (room) begin
                        if (!cur_given && (i_value > cur_top)) begin
                            n_top = i_value;
                        end
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_idx = '0;
                        n_acc = '0;
                        if (!room || r_ovf) begin
                            n_err = ERR_LEN;
                            n_state = S_FIN;
                        end else begin
                            n_err = ERR_OK;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_DIF;
            end
            S_DIF: begin
                if (d >= $signed({13'b0, r_limit})) begin
                    n_err = ERR_EXP;
                    n_state = S_FIN;
                end else if (d < -33'sd4194304) begin
                    n_term = '0;
                    n_state = S_NEXT;
                end else begin
                    n_rem = {d[32], d, 16'h0};
                    n_k = '0;
                    n_state = S_KRED;
                end
            end
            S_KRED: begin
                if (r_rem[49]) begin
                    n_rem = r_rem + L50;
                    n_k = r_k - 8'sd1;
                end else if (r_rem >= L50) begin
                    n_rem = r_rem - L50;
                    n_k = r_k + 8'sd1;
                end else begin
                    n_t = r_rem[31:0];
                    n_e = {2'b01, r_rem[31:0]};
                    n_n = 4'd2;
                    n_state = S_EMUL;
                end
            end
            S_EMUL: begin
                mul_a = r_t;
                mul_b = r_rem[31:0];
                n_prod = mul_p;
                n_state = S_EDIV;
            end
            S_EDIV: begin
                mul_a = r_prod[63:32];
                mul_b = recip({1'b0, r_n});
                n_prod = mul_p;
                n_t = r_prod[63:32];
                n_state = S_EDW;
            end
            S_EDW: begin
                n_t = fix_q;
                n_e = r_e + {2'b0, fix_q};
                if (r_n == 4'd14) begin
                    n_state = S_SHIFT;
                end else begin
                    n_n = r_n + 4'd1;
                    n_state = S_EMUL;
                end
            end
            S_SHIFT: begin
                n_term = term_val;
                n_state = S_NEXT;
            end
            S_NEXT: begin
                n_acc = sum65[64] ? '1 : sum65[63:0];
                if (({1'b0, r_idx} + CW'(1)) == r_count) begin
                    n_state = S_LOGCHK;
                end else begin
                    n_idx = r_idx + AW'(1);
                    n_state = S_RD;
                end
            end
            S_LOGCHK: begin
                if (r_acc == '0) begin
                    n_err = ERR_ZERO;
                    n_state = S_FIN;
                end else begin
                    n_a = r_acc;
                    n_p = 6'd63;
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (r_a[63]) begin
                    div_start = 1'b1;
                    div_dividend = {r_a[62:31], 32'b0};
                    div_divisor = {2'b10, r_a[62:31]};
                    div_bits = 7'd64;
                    n_state = S_ZDW;
                end else begin
                    n_a = {r_a[62:0], 1'b0};
                    n_p = r_p - 6'd1;
                end
            end
            S_ZDW: begin
                if (r_dcnt == '0) begin
                    n_z = r_dq[31:0];
                    n_state = S_Z2MUL;
                end
            end
            S_Z2MUL: begin
                mul_a = r_z;
                mul_b = r_z;
                n_prod = mul_p;
                n_state = S_Z2;
            end
            S_Z2: begin
                n_z2 = r_prod[63:32];
                n_zp = r_z;
                n_j = '0;
                n_lacc = '0;
                n_state = S_LDIV;
            end
            S_LDIV: begin
                mul_a = r_zp;
                mul_b = recip({r_j, 1'b1});
                n_prod = mul_p;
                n_state = S_LDW;
            end
            S_LDW: begin
                n_lacc = r_lacc + {5'b0, fix_q};
                n_state = (r_j == 4'd15) ? S_FIN : S_LMUL;
            end
            S_LMUL: begin
                mul_a = r_zp;
                mul_b = r_z2;
                n_prod = mul_p;
                n_state = S_LNX;
            end
            S_LNX: begin
                n_zp = r_prod[63:32];
                n_j = r_j + 4'd1;
                n_state = S_LDIV;
            end
            S_FIN: begin
                if (!(r_out_valid && i_out_stall)) begin
                    n_out_valid = 1'b1;
                    n_err_out = r_err;
                    if (r_err != ERR_OK) begin
                        n_log_sum = '0;
                    end else if (total > 48'sd2147483647) begin
                        n_log_sum = 32'sh7FFF_FFFF;
                    end else if (total < -48'sd2147483648) begin
                        n_log_sum = 32'sh8000_0000;
                    end else begin
                        n_log_sum = total[31:0];
                    end
                    n_count = '0;
                    n_given = 1'b0;
                    n_ovf = 1'b0;
                    n_top = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // bit-serial restoring divider
        if (div_start) begin
            n_dq = div_dividend;
            n_drem = '0;
            n_dv = div_divisor;
            n_dcnt = div_bits;
        end else if (r_dcnt != '0) begin
            n_drem = rem_ge ? (rem_sh - {1'b0, r_dv}) : rem_sh;
            n_dq = {r_dq[62:0], rem_ge};
            n_dcnt = r_dcnt - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && room) begin
            mem[r_count[AW-1:0]] <= i_value;
        end
        r_rdata <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= LIMIT_RESET;
            r_top <= '0;
            r_count <= '0;
            r_given <= 1'b0;
            r_ovf <= 1'b0;
            r_dcnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_limit <= n_limit;
            r_top <= n_top;
            r_count <= n_count;
            r_given <= n_given;
            r_ovf <= n_ovf;
            r_dcnt <= n_dcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;     r_rem <= n_rem;     r_k <= n_k;
        r_t <= n_t;         r_e <= n_e;         r_n <= n_n;
        r_term <= n_term;   r_acc <= n_acc;     r_a <= n_a;
        r_p <= n_p;         r_z <= n_z;         r_z2 <= n_z2;
        r_zp <= n_zp;       r_j <= n_j;         r_lacc <= n_lacc;
        r_err <= n_err;     r_prod <= n_prod;   r_dq <= n_dq;
        r_drem <= n_drem;   r_dv <= n_dv;
        r_log_sum <= n_log_sum;
        r_err_out <= n_err_out;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_log_sum    = r_log_sum;
    assign o_error_code = r_err_out;

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == CW'(DEPTH)))
        else $error("overflow flag without full store");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond depth");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_dcnt == '0))
        else $error("divider started while busy");
    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NORM) |-> (r_a != '0))
        else $error("normalizing a zero sum");

endmodule
`default_nettype wire
